[rtl/core/assert_macros.svh]
// Assertion macros shared by the point rotation RTL.
// Checks compile away when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop is a full property expression, checked at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("property violated");
// cond must never be true at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

[rtl/core/rpd_pkg.sv]
// Shared constants and elaboration-time functions for the point rotation block.
// No dependencies; used by the interfaces and every rpd module.
package rpd_pkg;

   localparam int ITERATIONS_DEF = 24;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int COORD_W    = 32;
   localparam int ANGLE_W    = 26;
   localparam int ANGLE_FRAC = 16;             // input angle is Q9.16 degrees
   localparam int GUARD_BITS = 16;
   localparam int GAIN_FRAC  = 32;
   localparam int PRE_SHIFT  = GAIN_FRAC - GUARD_BITS;
   localparam int CW1        = COORD_W + 1;    // holds a negated most negative coordinate
   localparam int DW         = COORD_W + GUARD_BITS + 4;
   localparam int WRAP_W     = ANGLE_W + 1;
   localparam int RES_W      = 24;             // residual in [-45, 45) degrees, Q16

   localparam logic [GAIN_FRAC-1:0] INV_GAIN = 32'h9B74EDA8;

   localparam logic signed [WRAP_W-1:0] TURN    = WRAP_W'(23592960);
   localparam logic signed [WRAP_W-1:0] QUARTER = WRAP_W'(5898240);
   localparam logic signed [WRAP_W-1:0] EIGHTH  = WRAP_W'(2949120);

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // long division, evaluated only for constants
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(1/d) in Q62 radians by the alternating series
   function automatic logic [63:0] atan_inv_q62(input logic [63:0] d);
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] d2;
      logic [63:0] k;
      p   = udiv(64'h4000_0000_0000_0000, d);
      sum = '0;
      k   = '0;
      d2  = d * d;
      while (p != 64'd0) begin
         term = udiv(p, 64'd2 * k + 64'd1);
         if (k[0])
            sum = sum - term;
         else
            sum = sum + term;
         p = udiv(p, d2);
         k = k + 64'd1;
      end
      return sum;
   endfunction

   // atan(2^-idx) in degrees with frac fraction bits, rounded to nearest
   function automatic logic [63:0] atan_deg(input int idx, input int frac);
      logic [63:0] qpi;
      logic [63:0] n;
      logic [63:0] q;
      logic [63:0] deg;
      if (idx == 0)
         return 64'd45 << frac;
      qpi = 64'd4 * atan_inv_q62(64'd5) - atan_inv_q62(64'd239);
      n   = atan_inv_q62(64'd1 << idx);
      q   = '0;
      for (int b = 0; b < 56; b++) begin
         n = n << 1;
         q = q << 1;
         if (n >= qpi) begin
            n    = n - qpi;
            q[0] = 1'b1;
         end
      end
      deg = q * 64'd45;
      deg = (deg + (64'd1 << (55 - frac))) >> (56 - frac);
      return deg;
   endfunction

endpackage

[rtl/core/rpd_req_if.sv]
// Request channel of the point rotation block: valid/ready plus point and angle.
// Depends on rpd_pkg for field widths.
interface rpd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [rpd_pkg::COORD_W-1:0]    x_in;
   logic signed [rpd_pkg::COORD_W-1:0]    y_in;
   logic signed [rpd_pkg::ANGLE_W-1:0]    angle_deg;

   modport source (output valid, x_in, y_in, angle_deg, input ready);
   modport sink   (input valid, x_in, y_in, angle_deg, output ready);
endinterface

[rtl/core/rpd_rsp_if.sv]
// Response channel of the point rotation block: valid/ready plus rotated point.
// Depends on rpd_pkg for field widths.
interface rpd_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [rpd_pkg::COORD_W-1:0]    x_out;
   logic signed [rpd_pkg::COORD_W-1:0]    y_out;
   logic                                  saturated;

   modport source (output valid, x_out, y_out, saturated, input ready);
   modport sink   (input valid, x_out, y_out, saturated, output ready);
endinterface

[rtl/core/rpd_prep.sv]
// Front end: angle wrap, quarter-turn swap, inverse-gain prescale (three stages).
// Depends on rpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpd_prep #(
   parameter int FRAC_BITS = rpd_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [rpd_pkg::COORD_W-1:0]   x_in,
   input  logic signed [rpd_pkg::COORD_W-1:0]   y_in,
   input  logic signed [rpd_pkg::ANGLE_W-1:0]   angle_deg,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [rpd_pkg::DW-1:0]        x_q,
   output logic signed [rpd_pkg::DW-1:0]        y_q,
   output logic signed [FRAC_BITS+7:0]          z_q
);

   localparam int ZW     = FRAC_BITS + 8;
   localparam int CW1    = rpd_pkg::CW1;
   localparam int PW     = 2 * CW1;
   localparam int DW     = rpd_pkg::DW;
   localparam int WRAP_W = rpd_pkg::WRAP_W;
   localparam int RES_W  = rpd_pkg::RES_W;
   localparam int PSH    = rpd_pkg::PRE_SHIFT;

   localparam logic signed [WRAP_W-1:0] TURN    = rpd_pkg::TURN;
   localparam logic signed [WRAP_W-1:0] QUARTER = rpd_pkg::QUARTER;
   localparam logic signed [WRAP_W-1:0] EIGHTH  = rpd_pkg::EIGHTH;
   localparam logic signed [CW1-1:0]    GAIN    = {1'b0, rpd_pkg::INV_GAIN};

   typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quad_type;

   logic                     rdy1, rdy2, rdy3;
   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [WRAP_W-1:0] a_base, a_once, a_wrap, a_res;
   logic signed [RES_W-1:0]  res;
   quad_type                 quad;
   logic signed [CW1-1:0]    x_ext, y_ext, x_rot, y_rot;
   logic signed [ZW-1:0]     z_scaled;
   logic signed [CW1-1:0]    x1_ff, y1_ff;
   logic signed [ZW-1:0]     z1_ff, z2_ff, z3_ff;
   logic signed [PW-1:0]     px_in, py_in, px_ff, py_ff, px_rnd, py_rnd;
   logic signed [DW-1:0]     x3_in, y3_in, x3_ff, y3_ff;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // wrap into one turn, then pick the nearest quarter (ties up)
   always_comb begin
      a_base = WRAP_W'(angle_deg);
      a_once = (a_base < 0) ? a_base + TURN : a_base;
      if (a_once < 0)
         a_wrap = a_once + TURN;
      else if (a_once >= TURN)
         a_wrap = a_once - TURN;
      else
         a_wrap = a_once;

      priority if (a_wrap >= TURN - EIGHTH) begin
         quad  = QUAD_0;
         a_res = a_wrap - TURN;
      end else if (a_wrap >= TURN - QUARTER - EIGHTH) begin
         quad  = QUAD_270;
         a_res = a_wrap - (TURN - QUARTER);
      end else if (a_wrap >= QUARTER + EIGHTH) begin
         quad  = QUAD_180;
         a_res = a_wrap - (QUARTER + QUARTER);
      end else if (a_wrap >= QUARTER - EIGHTH) begin
         quad  = QUAD_90;
         a_res = a_wrap - QUARTER;
      end else begin
         quad  = QUAD_0;
         a_res = a_wrap;
      end
      res = RES_W'(a_res);

      x_ext = CW1'(x_in);
      y_ext = CW1'(y_in);
      unique case (quad)
         QUAD_0: begin
            x_rot = x_ext;
            y_rot = y_ext;
         end
         QUAD_90: begin
            x_rot = -y_ext;
            y_rot = x_ext;
         end
         QUAD_180: begin
            x_rot = -x_ext;
            y_rot = -y_ext;
         end
         QUAD_270: begin
            x_rot = y_ext;
            y_rot = -x_ext;
         end
      endcase
   end

   generate
      if (FRAC_BITS >= rpd_pkg::ANGLE_FRAC) begin : g_up
         assign z_scaled = ZW'(res) <<< (FRAC_BITS - rpd_pkg::ANGLE_FRAC);
      end else begin : g_down
         localparam int DOWN = rpd_pkg::ANGLE_FRAC - FRAC_BITS;
         logic signed [RES_W-1:0] res_rnd;
         assign res_rnd  = res + (RES_W'(1) <<< (DOWN - 1));
         assign z_scaled = ZW'(res_rnd >>> DOWN);
      end
   endgenerate

   assign px_in  = PW'(x1_ff) * PW'(GAIN);
   assign py_in  = PW'(y1_ff) * PW'(GAIN);
   assign px_rnd = px_ff + (PW'(1) <<< (PSH - 1));
   assign py_rnd = py_ff + (PW'(1) <<< (PSH - 1));
   assign x3_in  = DW'(px_rnd >>> PSH);
   assign y3_in  = DW'(py_rnd >>> PSH);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
      if (rdy1 && in_valid) begin
         x1_ff <= x_rot;
         y1_ff <= y_rot;
         z1_ff <= z_scaled;
      end
      if (rdy2 && v1_ff) begin
         px_ff <= px_in;
         py_ff <= py_in;
         z2_ff <= z1_ff;
      end
      if (rdy3 && v2_ff) begin
         x3_ff <= x3_in;
         y3_ff <= y3_in;
         z3_ff <= z2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign x_q       = x3_ff;
   assign y_q       = y3_ff;
   assign z_q       = z3_ff;

   // a stalled front end is a full front end
   `ASSERT_PROP(a_prep_full, clock, reset, !in_ready |-> (v1_ff && v2_ff && v3_ff))

endmodule

[rtl/core/rpd_cell.sv]
// One CORDIC micro-rotation stage with its own valid/ready register slice.
// Depends on rpd_pkg (atan table function) and assert_macros.svh.
`include "assert_macros.svh"

module rpd_cell #(
   parameter int FRAC_BITS = rpd_pkg::FRAC_BITS_DEF,
   parameter int STAGE     = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [rpd_pkg::DW-1:0]   x_d,
   input  logic signed [rpd_pkg::DW-1:0]   y_d,
   input  logic signed [FRAC_BITS+7:0]     z_d,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [rpd_pkg::DW-1:0]   x_q,
   output logic signed [rpd_pkg::DW-1:0]   y_q,
   output logic signed [FRAC_BITS+7:0]     z_q
);

   localparam int ZW = FRAC_BITS + 8;
   localparam int DW = rpd_pkg::DW;
   localparam logic [63:0]          ANGLE_RAW = rpd_pkg::atan_deg(STAGE, FRAC_BITS);
   localparam logic signed [ZW-1:0] ANGLE     = ANGLE_RAW[ZW-1:0];

   logic                 rdy;
   logic                 v_ff;
   logic signed [DW-1:0] dx, dy, x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;

   assign rdy      = !v_ff || out_ready;
   assign in_ready = rdy;
   assign dx       = y_d >>> STAGE;
   assign dy       = x_d >>> STAGE;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (rdy) begin
         v_ff <= in_valid;
      end
      if (rdy && in_valid) begin
         if (!z_d[ZW-1]) begin
            x_ff <= x_d - dx;
            y_ff <= y_d + dy;
            z_ff <= z_d - ANGLE;
         end else begin
            x_ff <= x_d + dx;
            y_ff <= y_d - dy;
            z_ff <= z_d + ANGLE;
         end
      end
   end

   assign out_valid = v_ff;
   assign x_q       = x_ff;
   assign y_q       = y_ff;
   assign z_q       = z_ff;

   `ASSERT_PROP(a_cell_hold, clock, reset, (v_ff && !out_ready) |=> (v_ff && $stable(x_ff) && $stable(z_ff)))
   // residual angle stays well inside +/-64 degrees
   `ASSERT_NEVER(a_cell_zrange, clock, reset, v_ff && (z_ff[ZW-1] != z_ff[ZW-2]))

endmodule

[rtl/core/rpd_post.sv]
// Output stage: drop guard bits with round half up, clip to Q16.16, hold result.
// Depends on rpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpd_post (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [rpd_pkg::DW-1:0]        x_d,
   input  logic signed [rpd_pkg::DW-1:0]        y_d,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [rpd_pkg::COORD_W-1:0]   x_out,
   output logic signed [rpd_pkg::COORD_W-1:0]   y_out,
   output logic                                 saturated
);

   localparam int DW = rpd_pkg::DW;
   localparam int CW = rpd_pkg::COORD_W;
   localparam int G  = rpd_pkg::GUARD_BITS;

   logic                 rdy;
   logic                 v_ff, sat_ff;
   logic signed [DW-1:0] xr, yr;
   logic                 x_fits, y_fits;
   logic signed [CW-1:0] x_clip, y_clip, x_ff, y_ff;

   assign rdy      = !v_ff || out_ready;
   assign in_ready = rdy;

   assign xr     = (x_d + (DW'(1) <<< (G - 1))) >>> G;
   assign yr     = (y_d + (DW'(1) <<< (G - 1))) >>> G;
   // fits when all bits from the top down to the sign position agree
   assign x_fits = (&xr[DW-1:CW-1]) || !(|xr[DW-1:CW-1]);
   assign y_fits = (&yr[DW-1:CW-1]) || !(|yr[DW-1:CW-1]);
   assign x_clip = x_fits ? xr[CW-1:0] : (xr[DW-1] ? rpd_pkg::COORD_MIN : rpd_pkg::COORD_MAX);
   assign y_clip = y_fits ? yr[CW-1:0] : (yr[DW-1] ? rpd_pkg::COORD_MIN : rpd_pkg::COORD_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (rdy) begin
         v_ff <= in_valid;
      end
      if (rdy && in_valid) begin
         x_ff   <= x_clip;
         y_ff   <= y_clip;
         sat_ff <= !x_fits || !y_fits;
      end
   end

   assign out_valid = v_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign saturated = sat_ff;

   `ASSERT_PROP(a_post_satbound, clock, reset, (v_ff && sat_ff) |-> (x_ff == rpd_pkg::COORD_MAX || x_ff == rpd_pkg::COORD_MIN || y_ff == rpd_pkg::COORD_MAX || y_ff == rpd_pkg::COORD_MIN))

endmodule

[rtl/core/rotate_point_by_degrees.sv]
// Rotates a Q16.16 point (x, y) counterclockwise about the origin by a Q9.16 angle in
// degrees and returns the rotated point, clipped to Q16.16 with a saturated flag. Any
// 26-bit angle is accepted and wrapped to one turn; whole quarter turns are applied
// exactly, the residual by a chain of ITERATIONS CORDIC cells. The block is fully
// pipelined: it takes one request per cycle unless the response side stalls, and each
// request passes three front-end stages, one register per cell and one output register.
// Every stage has its own valid/ready slice, so a stalled response only stops the
// requests queued behind it and bubbles are squeezed out. Depends on rpd_pkg,
// rpd_req_if, rpd_rsp_if, rpd_prep, rpd_cell, rpd_post and assert_macros.svh.
`include "assert_macros.svh"

module rotate_point_by_degrees #(
   parameter int ITERATIONS = rpd_pkg::ITERATIONS_DEF,
   parameter int FRAC_BITS  = rpd_pkg::FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rpd_req_if.sink    req,
   rpd_rsp_if.source  rsp
);

   localparam int ZW = FRAC_BITS + 8;
   localparam int DW = rpd_pkg::DW;

   logic                 c_valid [0:ITERATIONS];
   logic                 c_ready [0:ITERATIONS];
   logic signed [DW-1:0] c_x     [0:ITERATIONS];
   logic signed [DW-1:0] c_y     [0:ITERATIONS];
   logic signed [ZW-1:0] c_z     [0:ITERATIONS];

   rpd_prep #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .x_in      (req.x_in),
      .y_in      (req.y_in),
      .angle_deg (req.angle_deg),
      .out_valid (c_valid[0]),
      .out_ready (c_ready[0]),
      .x_q       (c_x[0]),
      .y_q       (c_y[0]),
      .z_q       (c_z[0])
   );

   generate
      for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
         rpd_cell #(
            .FRAC_BITS (FRAC_BITS),
            .STAGE     (k)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (c_valid[k]),
            .in_ready  (c_ready[k]),
            .x_d       (c_x[k]),
            .y_d       (c_y[k]),
            .z_d       (c_z[k]),
            .out_valid (c_valid[k+1]),
            .out_ready (c_ready[k+1]),
            .x_q       (c_x[k+1]),
            .y_q       (c_y[k+1]),
            .z_q       (c_z[k+1])
         );
      end
   endgenerate

   rpd_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid[ITERATIONS]),
      .in_ready  (c_ready[ITERATIONS]),
      .x_d       (c_x[ITERATIONS]),
      .y_d       (c_y[ITERATIONS]),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .x_out     (rsp.x_out),
      .y_out     (rsp.y_out),
      .saturated (rsp.saturated)
   );

   // backpressure at the input only once the whole chain, output included, is full
   `ASSERT_PROP(a_top_full, clock, reset, !req.ready |-> rsp.valid)

endmodule

[test/rotate_point_by_degrees_tb.sv]
// Testbench for rotate_point_by_degrees: drives points and angles on the request channel
// and checks every rotated point against a bit-exact CORDIC predictor kept in this module.
// Depends on rpd_pkg, rpd_req_if, rpd_rsp_if and the rotate_point_by_degrees RTL.
module rotate_point_by_degrees_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITERATIONS = rpd_pkg::ITERATIONS_DEF;
   localparam int FRAC_BITS  = rpd_pkg::FRAC_BITS_DEF;
   localparam int GUARD      = rpd_pkg::GUARD_BITS;
   localparam int PRE_SHIFT  = rpd_pkg::PRE_SHIFT;
   localparam int ANG_UP     = (FRAC_BITS >= rpd_pkg::ANGLE_FRAC) ?
                               FRAC_BITS - rpd_pkg::ANGLE_FRAC : 0;
   localparam int ANG_DOWN   = (FRAC_BITS < rpd_pkg::ANGLE_FRAC) ?
                               rpd_pkg::ANGLE_FRAC - FRAC_BITS : 0;
   localparam longint GAIN_Q32   = longint'(rpd_pkg::INV_GAIN);
   localparam longint DEG_TURN   = 64'sd23592960;
   localparam longint DEG_QUART  = 64'sd5898240;
   localparam longint DEG_EIGHTH = 64'sd2949120;
   localparam int DRAIN_CYCLES   = ITERATIONS + 12;

   localparam logic signed [31:0] ONE     = 32'sh0001_0000;
   localparam logic signed [31:0] C_MAX   = rpd_pkg::COORD_MAX;
   localparam logic signed [31:0] C_MIN   = rpd_pkg::COORD_MIN;
   localparam logic signed [25:0] A_MAX   = 26'sh1FF_FFFF;
   localparam logic signed [25:0] A_MIN   = 26'sh200_0000;

   typedef enum logic [1:0] {QTR_0, QTR_90, QTR_180, QTR_270} quarter_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               sat;
   } rotated_type;

   logic clock;
   logic reset;

   rpd_req_if req_if ();
   rpd_rsp_if rsp_if ();

   rotate_point_by_degrees dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   longint      atan_deg_tab [ITERATIONS];
   rotated_type expected_points [$];
   int          mismatch_count = 0;
   bit          steady_flow    = 0;

   always #5 clock = ~clock;

   // atan(1/d) in Q62 radians, alternating Taylor series
   function automatic longint unsigned atan_recip_q62(input longint unsigned d);
      longint unsigned pw;
      longint unsigned acc;
      longint unsigned dsq;
      longint unsigned n;
      pw  = 64'h4000_0000_0000_0000 / d;
      acc = 0;
      dsq = d * d;
      n   = 0;
      while (pw != 0) begin
         if (n[0])
            acc = acc - pw / (2 * n + 1);
         else
            acc = acc + pw / (2 * n + 1);
         pw = pw / dsq;
         n++;
      end
      return acc;
   endfunction

   task automatic build_atan_table();
      longint unsigned quarter_pi;
      longint unsigned num;
      longint unsigned quo;
      longint unsigned deg;
      quarter_pi = 4 * atan_recip_q62(64'd5) - atan_recip_q62(64'd239);
      atan_deg_tab[0] = longint'(45) <<< FRAC_BITS;
      for (int i = 1; i < ITERATIONS; i++) begin
         num = (i <= 62) ? atan_recip_q62(64'd1 << i) : 64'd0;
         quo = 0;
         // num / quarter_pi as a 56-bit fraction, i.e. angle in units of 45 degrees
         repeat (56) begin
            num = num << 1;
            quo = quo << 1;
            if (num >= quarter_pi) begin
               num = num - quarter_pi;
               quo = quo | 64'd1;
            end
         end
         deg = quo * 45;
         deg = (deg + (64'd1 << (55 - FRAC_BITS))) >> (56 - FRAC_BITS);
         atan_deg_tab[i] = longint'(deg);
      end
   endtask

   function automatic longint round_shift(input longint v, input int s);
      if (s == 0)
         return v;
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [31:0] clip_coord(input longint v, inout logic sat);
      if (v > longint'(C_MAX)) begin
         sat = 1'b1;
         return C_MAX;
      end
      if (v < longint'(C_MIN)) begin
         sat = 1'b1;
         return C_MIN;
      end
      return v[31:0];
   endfunction

   function automatic rotated_type rotate_point(input logic signed [31:0] xi,
                                                input logic signed [31:0] yi,
                                                input logic signed [25:0] ai);
      longint      x, y, a, q, r, t, z, dx, dy;
      logic        sat;
      rotated_type res;
      x   = longint'(xi);
      y   = longint'(yi);
      a   = longint'(ai);
      sat = 1'b0;
      while (a < 0)
         a += DEG_TURN;
      while (a >= DEG_TURN)
         a -= DEG_TURN;
      // nearest quarter turn, ties up, so the residual sits in [-45, 45)
      q = (a + DEG_EIGHTH) / DEG_QUART;
      r = a - q * DEG_QUART;
      case (quarter_type'(q[1:0]))
         QTR_90: begin
            t = x;
            x = -y;
            y = t;
         end
         QTR_180: begin
            x = -x;
            y = -y;
         end
         QTR_270: begin
            t = x;
            x = y;
            y = -t;
         end
         default: ;
      endcase
      x = round_shift(x * GAIN_Q32, PRE_SHIFT);
      y = round_shift(y * GAIN_Q32, PRE_SHIFT);
      z = (ANG_DOWN != 0) ? round_shift(r, ANG_DOWN) : (r <<< ANG_UP);
      for (int i = 0; i < ITERATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= atan_deg_tab[i];
         end else begin
            x += dx;
            y -= dy;
            z += atan_deg_tab[i];
         end
      end
      res.x   = clip_coord(round_shift(x, GUARD), sat);
      res.y   = clip_coord(round_shift(y, GUARD), sat);
      res.sat = sat;
      return res;
   endfunction

   // one request: random gap, then hold valid until ready
   task automatic send_request(input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic signed [25:0] ang);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.x_in      <= x;
      req_if.y_in      <= y;
      req_if.angle_deg <= ang;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      expected_points.push_back(rotate_point(x, y, ang));
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_points.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_quarter_turns();
      logic signed [31:0] px;
      logic signed [31:0] py;
      px = ONE;
      py = ONE >>> 1;
      send_request(px, py, 26'sd0);
      send_request(px, py, 26'(DEG_QUART));
      send_request(px, py, 26'(2 * DEG_QUART));
      send_request(px, py, 26'(3 * DEG_QUART));
      send_request(px, py, 26'(-DEG_QUART));
      // 45 degrees is a tie and goes to the upper quarter; -45 stays in quarter zero
      send_request(px, py, 26'(DEG_EIGHTH));
      send_request(px, py, 26'(-DEG_EIGHTH));
      send_request(px, py, 26'(DEG_EIGHTH - 1));
      send_request(px, py, 26'(3 * DEG_EIGHTH));
      send_request(px, py, 26'(7 * DEG_EIGHTH));
   endtask

   task automatic test_angle_wrap();
      send_request(ONE, -ONE, 26'(DEG_TURN));
      send_request(ONE, -ONE, 26'(-DEG_TURN));
      send_request(ONE, -ONE, A_MAX);
      send_request(ONE, -ONE, A_MIN);
      send_request(ONE, -ONE, 26'(DEG_TURN - 1));
   endtask

   task automatic test_coordinate_extremes();
      // negating the most negative coordinate must not wrap before the final clip
      send_request(C_MIN, C_MIN, 26'(DEG_QUART));
      send_request(C_MIN, 32'sd0, 26'(2 * DEG_QUART));
      send_request(C_MAX, C_MAX, 26'(DEG_EIGHTH));
      send_request(C_MIN, C_MAX, 26'(-DEG_EIGHTH));
      send_request(C_MAX, C_MIN, 26'sd0);
      send_request(32'sd0, 32'sd0, A_MAX);
      send_request(-32'sd1, -32'sd1, 26'sd1);
      send_request(C_MAX, C_MAX, 26'(3 * DEG_QUART));
      send_request(-32'sd1, 32'sd1, -26'sd1);
   endtask

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 9))
         4, 5, 6: return $urandom_range(0, 32'h0020_0000) - 32'sh0010_0000;
         7:       return $urandom_range(0, 1) ? C_MAX - $urandom_range(0, 255)
                                              : C_MIN + $urandom_range(0, 255);
         8:       return $urandom_range(0, 2) - 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [25:0] pick_angle();
      longint a;
      case ($urandom_range(0, 9))
         7:       return 26'($urandom);
         8: begin
            a = longint'($urandom_range(0, 16)) * DEG_EIGHTH - DEG_TURN;
            return 26'(a + $urandom_range(0, 4) - 2);
         end
         9: begin
            // just around the quarter boundaries
            a = longint'($urandom_range(0, 7)) * DEG_QUART - DEG_TURN + DEG_EIGHTH;
            return 26'(a + $urandom_range(0, 2) - 1);
         end
         default: return 26'(longint'($urandom_range(0, 32'(2 * DEG_TURN))) - DEG_TURN);
      endcase
   endfunction

   task automatic test_random_points(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 250 == 0)
            steady_flow = ($urandom_range(0, 3) == 0);
         if (n == count / 2)
            drain_results();
         send_request(pick_coord(), pick_coord(), pick_angle());
      end
   endtask

   // response side: random stalls, compare each rotated point in order
   initial begin
      rotated_type exp_pt;
      int          stall;
      rsp_if.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 4);
         repeat (stall) begin
            rsp_if.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1 || rsp_if.ready !== 1'b1);
         if (expected_points.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result x=%0d y=%0d sat=%0b", $time,
                     rsp_if.x_out, rsp_if.y_out, rsp_if.saturated);
         end else begin
            exp_pt = expected_points.pop_front();
            if (rsp_if.x_out !== exp_pt.x || rsp_if.y_out !== exp_pt.y ||
                rsp_if.saturated !== exp_pt.sat) begin
               mismatch_count++;
               $display("%0t: mismatch expected x=%0d y=%0d sat=%0b, got x=%0d y=%0d sat=%0b",
                        $time, exp_pt.x, exp_pt.y, exp_pt.sat,
                        rsp_if.x_out, rsp_if.y_out, rsp_if.saturated);
            end
         end
      end
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.x_in      = '0;
      req_if.y_in      = '0;
      req_if.angle_deg = '0;
      build_atan_table();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_quarter_turns();
      test_angle_wrap();
      drain_results();
      test_coordinate_extremes();
      drain_results();
      test_random_points(1500);
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_points.size() == 0)
         $display("rotate_point_by_degrees_tb: clean");
      else
         $display("rotate_point_by_degrees_tb: errors");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("rotate_point_by_degrees_tb: errors");
      $finish;
   end

endmodule
